[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers used by the block that checks itself.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/u8d_pkg.sv]
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types, constants and lead-byte decoding for the UTF-8 byte decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package u8d_pkg;

    localparam int CP_W     = 21;
    localparam int STATUS_W = 2;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [STATUS_W-1:0] ST_READY = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MORE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ERROR = 2'd2;

    localparam logic [7:0] ASCII_MAX  = 8'h7F;
    localparam logic [7:0] LEAD2_MIN  = 8'hC2;
    localparam logic [7:0] LEAD2_MAX  = 8'hDF;
    localparam logic [7:0] LEAD3_MIN  = 8'hE0;
    localparam logic [7:0] LEAD3_SURR = 8'hED;
    localparam logic [7:0] LEAD3_MAX  = 8'hEF;
    localparam logic [7:0] LEAD4_MIN  = 8'hF0;
    localparam logic [7:0] LEAD4_MAX  = 8'hF4;
    localparam logic [7:0] E0_LO      = 8'hA0;
    localparam logic [7:0] ED_HI      = 8'h9F;
    localparam logic [7:0] F0_LO      = 8'h90;
    localparam logic [7:0] F4_HI      = 8'h8F;
    localparam logic [7:0] CONT_LO    = 8'h80;
    localparam logic [7:0] CONT_HI    = 8'hBF;

    // One queue entry: the final result of a byte, optionally preceded by
    // an error beat when a continuation byte fell outside its window.
    typedef struct packed {
        logic                err_first;
        logic [CP_W-1:0]     code_point;
        logic [STATUS_W-1:0] status;
    } entry_t;

    typedef struct packed {
        logic not_empty;
        logic not_full;
    } q_stat_t;

    // Outcome of a byte taken as a lead byte, with the decoder state it leaves.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CP_W-1:0]     code_point;
        logic [1:0]          needed;
        logic [CP_W-1:0]     partial;
        logic [7:0]          lo;
        logic [7:0]          hi;
    } lead_t;

    function automatic lead_t take_lead(input logic [7:0] b);
        lead_t l;
        l.status     = ST_ERROR;
        l.code_point = '0;
        l.needed     = 2'd0;
        l.partial    = '0;
        l.lo         = CONT_LO;
        l.hi         = CONT_HI;
        if (b <= ASCII_MAX) begin
            l.status     = ST_READY;
            l.code_point = CP_W'(b);
        end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
            l.status  = ST_MORE;
            l.needed  = 2'd1;
            l.partial = CP_W'(b[4:0]);
        end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
            l.status  = ST_MORE;
            l.needed  = 2'd2;
            l.partial = CP_W'(b[3:0]);
            if (b == LEAD3_MIN) begin
                l.lo = E0_LO;
            end else if (b == LEAD3_SURR) begin
                l.hi = ED_HI;
            end
        end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
            l.status  = ST_MORE;
            l.needed  = 2'd3;
            l.partial = CP_W'(b[2:0]);
            if (b == LEAD4_MIN) begin
                l.lo = F0_LO;
            end else if (b == LEAD4_MAX) begin
                l.hi = F4_HI;
            end
        end
        return l;
    endfunction

endpackage

[src/u8d_front.sv]
// ----------------------------------------------------------------------------
// u8d_front
// Accepts bytes, runs the sequence state and pushes one entry per byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u8d_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_byte_in,
    input  u8d_pkg::q_stat_t     q_stat,
    output logic                 push,
    output u8d_pkg::entry_t      push_entry
);

    logic [u8d_pkg::CP_W-1:0] partial_reg, partial_next;
    logic [1:0]               needed_reg, needed_next;
    logic [1:0]               seen_reg, seen_next;
    logic [7:0]               lo_reg, lo_next;
    logic [7:0]               hi_reg, hi_next;

    u8d_pkg::lead_t           lead;
    logic [u8d_pkg::CP_W-1:0] shifted;
    logic [1:0]               seen_inc;

    assign s_ready = q_stat.not_full;
    assign push    = s_valid && s_ready;

    assign lead     = u8d_pkg::take_lead(s_byte_in);
    assign shifted  = {partial_reg[u8d_pkg::CP_W-7:0], s_byte_in[5:0]};
    assign seen_inc = seen_reg + 2'd1;

    always_comb begin
        push_entry.err_first  = 1'b0;
        push_entry.code_point = lead.code_point;
        push_entry.status     = lead.status;
        partial_next = lead.partial;
        needed_next  = lead.needed;
        seen_next    = 2'd0;
        lo_next      = lead.lo;
        hi_next      = lead.hi;
        if (needed_reg != 2'd0) begin
            if (s_byte_in < lo_reg || s_byte_in > hi_reg) begin
                // Out of window: error, then the byte restarts as a lead.
                push_entry.err_first = 1'b1;
            end else if (seen_inc != needed_reg) begin
                push_entry.code_point = '0;
                push_entry.status     = u8d_pkg::ST_MORE;
                partial_next = shifted;
                needed_next  = needed_reg;
                seen_next    = seen_inc;
                lo_next      = u8d_pkg::CONT_LO;
                hi_next      = u8d_pkg::CONT_HI;
            end else begin
                push_entry.code_point = shifted;
                push_entry.status     = u8d_pkg::ST_READY;
                partial_next = '0;
                needed_next  = 2'd0;
                lo_next      = u8d_pkg::CONT_LO;
                hi_next      = u8d_pkg::CONT_HI;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_reg <= '0;
            needed_reg  <= 2'd0;
            seen_reg    <= 2'd0;
            lo_reg      <= u8d_pkg::CONT_LO;
            hi_reg      <= u8d_pkg::CONT_HI;
        end else if (push) begin
            partial_reg <= partial_next;
            needed_reg  <= needed_next;
            seen_reg    <= seen_next;
            lo_reg      <= lo_next;
            hi_reg      <= hi_next;
        end
    end

endmodule

[src/u8d_fifo.sv]
// ----------------------------------------------------------------------------
// u8d_fifo
// Short queue of decoded entries between the front and back halves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u8d_fifo #(
    parameter int DEPTH = u8d_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  u8d_pkg::entry_t  push_entry,
    input  logic             pop,
    output u8d_pkg::entry_t  head_entry,
    output u8d_pkg::q_stat_t q_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    u8d_pkg::entry_t  slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign q_stat.not_empty = (count_reg != '0);
    assign q_stat.not_full  = (count_reg != FULL_CNT);
    assign head_entry       = slots[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[src/u8d_back.sv]
// ----------------------------------------------------------------------------
// u8d_back
// Expands queue entries into one or two result beats in an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u8d_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  u8d_pkg::q_stat_t             q_stat,
    input  u8d_pkg::entry_t              head_entry,
    output logic                         pop,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [u8d_pkg::CP_W-1:0]     m_code_point,
    output logic [u8d_pkg::STATUS_W-1:0] m_status,
    output logic                         m_last
);

    logic                         valid_reg, valid_next;
    logic [u8d_pkg::CP_W-1:0]     cp_reg, cp_next;
    logic [u8d_pkg::STATUS_W-1:0] status_reg, status_next;
    logic                         last_reg, last_next;
    logic                         pend_reg, pend_next;
    logic [u8d_pkg::CP_W-1:0]     pend_cp_reg, pend_cp_next;
    logic [u8d_pkg::STATUS_W-1:0] pend_status_reg, pend_status_next;
    logic                         out_free;

    assign out_free = !valid_reg || m_ready;
    assign pop      = out_free && !pend_reg && q_stat.not_empty;

    always_comb begin
        valid_next       = valid_reg;
        cp_next          = cp_reg;
        status_next      = status_reg;
        last_next        = last_reg;
        pend_next        = pend_reg;
        pend_cp_next     = pend_cp_reg;
        pend_status_next = pend_status_reg;
        if (out_free) begin
            if (pend_reg) begin
                valid_next  = 1'b1;
                cp_next     = pend_cp_reg;
                status_next = pend_status_reg;
                last_next   = 1'b1;
                pend_next   = 1'b0;
            end else if (q_stat.not_empty) begin
                valid_next = 1'b1;
                if (head_entry.err_first) begin
                    cp_next          = '0;
                    status_next      = u8d_pkg::ST_ERROR;
                    last_next        = 1'b0;
                    pend_next        = 1'b1;
                    pend_cp_next     = head_entry.code_point;
                    pend_status_next = head_entry.status;
                end else begin
                    cp_next     = head_entry.code_point;
                    status_next = head_entry.status;
                    last_next   = 1'b1;
                end
            end else begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
        cp_reg          <= cp_next;
        status_reg      <= status_next;
        last_reg        <= last_next;
        pend_cp_reg     <= pend_cp_next;
        pend_status_reg <= pend_status_next;
    end

    assign m_valid      = valid_reg;
    assign m_code_point = cp_reg;
    assign m_status     = status_reg;
    assign m_last       = last_reg;

endmodule

[src/utf8_byte_decoder_unit.sv]
// ----------------------------------------------------------------------------
// utf8_byte_decoder_unit
// Strict UTF-8 decoder: one byte in per beat, one or two status beats out.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Ports                                Beat carries
//   s_        in         s_valid s_ready s_byte_in            one stream byte
//   m_        out        m_valid m_ready m_code_point         one result
//                        m_status m_last
//
// One byte is accepted every cycle while the queue has room. A byte gives
// one result beat, or two when a continuation byte falls outside its window
// (an error beat, then the byte decoded again as a lead byte); the single
// output register therefore sets the rate at one result beat per cycle while
// m_ready is high. Each result passes through the queue and then the output
// register. Reset is synchronous and active low; it clears the sequence
// state, the queue and the output valid. A stall on m_ready fills the queue
// first, and s_ready falls only once the queue is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module utf8_byte_decoder_unit #(
    parameter int FIFO_DEPTH = u8d_pkg::QUEUE_DEPTH
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [7:0]                   s_byte_in,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [u8d_pkg::CP_W-1:0]     m_code_point,
    output logic [u8d_pkg::STATUS_W-1:0] m_status,
    output logic                         m_last
);

    // Front to queue: the decoded entry of each accepted byte.
    logic             push;
    u8d_pkg::entry_t  push_entry;
    // Queue to back: the oldest entry and the queue's fill status.
    logic             pop;
    u8d_pkg::entry_t  head_entry;
    u8d_pkg::q_stat_t q_stat;

    // The front keeps the open sequence (partial value, counts and the window
    // for the next continuation byte) and classifies each byte on arrival.
    u8d_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_byte_in  (s_byte_in),
        .q_stat     (q_stat),
        .push       (push),
        .push_entry (push_entry)
    );

    u8d_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .q_stat     (q_stat)
    );

    // The back turns an entry into its result beats and holds each beat in
    // the output register until it is taken.
    u8d_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_stat       (q_stat),
        .head_entry   (head_entry),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_code_point (m_code_point),
        .m_status     (m_status),
        .m_last       (m_last)
    );

    // A code point is only carried by a ready result.
    `ASSERT_IMP(a_cp_zero, aclk, aresetn,
                m_valid && (m_status != u8d_pkg::ST_READY), m_code_point == '0,
                "code point set on a non-ready result")

    // Only the error beat of a two-beat byte lacks last.
    `ASSERT_IMP(a_first_is_error, aclk, aresetn,
                m_valid && !m_last, m_status == u8d_pkg::ST_ERROR,
                "non-last beat is not an error")

    // The second beat of a byte follows its error beat without a gap.
    `ASSERT_NXT(a_second_follows, aclk, aresetn,
                m_valid && m_ready && !m_last, m_valid && m_last,
                "second beat of a byte missing")

    // The queue never grants and pushes when full.
    `ASSERT_IMP(a_no_overflow, aclk, aresetn, push, q_stat.not_full,
                "push into a full queue")

endmodule

[bench/tb_utf8_byte_decoder_unit.sv]
// ----------------------------------------------------------------------------
// tb_utf8_byte_decoder_unit
// Self-checking bench for the strict UTF-8 byte decoder. A short directed
// stream covers the byte classes and every narrowed continuation window. A
// long random stream follows, mostly well-formed sequences and partly broken
// ones. Each byte beat is decoded in the bench as well, and every result beat
// is compared field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Bench-side UTF-8 decoder plus the queue of result beats it predicts.
class utf8_scoreboard;

    typedef struct {
        logic [u8d_pkg::CP_W-1:0]     code_point;
        logic [u8d_pkg::STATUS_W-1:0] status;
        logic                         last;
    } result_t;

    result_t                  decoded_q[$];
    int                       failures;

    logic [u8d_pkg::CP_W-1:0] seq_value;
    logic [1:0]               seq_needed;
    logic [1:0]               seq_seen;
    logic [7:0]               win_lo;
    logic [7:0]               win_hi;

    function new();
        failures = 0;
        clear_sequence();
    endfunction

    function void clear_sequence();
        seq_value  = '0;
        seq_needed = 2'd0;
        seq_seen   = 2'd0;
        win_lo     = u8d_pkg::CONT_LO;
        win_hi     = u8d_pkg::CONT_HI;
    endfunction

    function void push_result(input logic [u8d_pkg::CP_W-1:0] cp,
                              input logic [u8d_pkg::STATUS_W-1:0] st,
                              input logic fin);
        result_t r;
        r.code_point = cp;
        r.status     = st;
        r.last       = fin;
        decoded_q.push_back(r);
    endfunction

    // Takes a byte with no sequence open and opens one if it is a lead byte.
    function logic [u8d_pkg::STATUS_W-1:0] start_sequence(
            input logic [7:0] b, output logic [u8d_pkg::CP_W-1:0] cp);
        cp = '0;
        if (b <= u8d_pkg::ASCII_MAX) begin
            cp = u8d_pkg::CP_W'(b);
            return u8d_pkg::ST_READY;
        end
        if (b >= u8d_pkg::LEAD2_MIN && b <= u8d_pkg::LEAD2_MAX) begin
            seq_needed = 2'd1;
            seq_value  = u8d_pkg::CP_W'(b[4:0]);
            return u8d_pkg::ST_MORE;
        end
        if (b >= u8d_pkg::LEAD3_MIN && b <= u8d_pkg::LEAD3_MAX) begin
            if (b == u8d_pkg::LEAD3_MIN) begin
                win_lo = u8d_pkg::E0_LO;
            end else if (b == u8d_pkg::LEAD3_SURR) begin
                win_hi = u8d_pkg::ED_HI;
            end
            seq_needed = 2'd2;
            seq_value  = u8d_pkg::CP_W'(b[3:0]);
            return u8d_pkg::ST_MORE;
        end
        if (b >= u8d_pkg::LEAD4_MIN && b <= u8d_pkg::LEAD4_MAX) begin
            if (b == u8d_pkg::LEAD4_MIN) begin
                win_lo = u8d_pkg::F0_LO;
            end else if (b == u8d_pkg::LEAD4_MAX) begin
                win_hi = u8d_pkg::F4_HI;
            end
            seq_needed = 2'd3;
            seq_value  = u8d_pkg::CP_W'(b[2:0]);
            return u8d_pkg::ST_MORE;
        end
        return u8d_pkg::ST_ERROR;
    endfunction

    // Called for every accepted byte beat; queues the one or two results.
    function void decode_byte(input logic [7:0] b);
        logic [u8d_pkg::CP_W-1:0]     cp;
        logic [u8d_pkg::STATUS_W-1:0] st;
        if (seq_needed == 2'd0) begin
            st = start_sequence(b, cp);
            push_result(cp, st, 1'b1);
            return;
        end
        if (b < win_lo || b > win_hi) begin
            // Abandon the sequence, then decode the same byte as a lead.
            clear_sequence();
            push_result('0, u8d_pkg::ST_ERROR, 1'b0);
            st = start_sequence(b, cp);
            push_result(cp, st, 1'b1);
            return;
        end
        win_lo    = u8d_pkg::CONT_LO;
        win_hi    = u8d_pkg::CONT_HI;
        seq_value = {seq_value[u8d_pkg::CP_W-7:0], b[5:0]};
        seq_seen  = seq_seen + 2'd1;
        if (seq_seen != seq_needed) begin
            push_result('0, u8d_pkg::ST_MORE, 1'b1);
        end else begin
            cp = seq_value;
            clear_sequence();
            push_result(cp, u8d_pkg::ST_READY, 1'b1);
        end
    endfunction

    function void check_result(input logic [u8d_pkg::CP_W-1:0] cp,
                               input logic [u8d_pkg::STATUS_W-1:0] st,
                               input logic fin);
        result_t want;
        if (decoded_q.size() == 0) begin
            $error("unexpected result beat: code_point %h status %0d last %0d",
                   cp, st, fin);
            failures++;
            return;
        end
        want = decoded_q.pop_front();
        if (cp !== want.code_point) begin
            $error("code_point: expected %h, got %h", want.code_point, cp);
            failures++;
        end
        if (st !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, st);
            failures++;
        end
        if (fin !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, fin);
            failures++;
        end
    endfunction

    function int waiting();
        return decoded_q.size();
    endfunction

endclass

module tb_utf8_byte_decoder_unit;

    localparam int RANDOM_BYTES = 700;

    logic                         aclk         = 1'b0;
    logic                         aresetn      = 1'b0;
    logic                         s_valid      = 1'b0;
    logic                         s_ready;
    logic [7:0]                   s_byte_in    = 8'h00;
    logic                         m_valid;
    logic                         m_ready      = 1'b0;
    logic [u8d_pkg::CP_W-1:0]     m_code_point;
    logic [u8d_pkg::STATUS_W-1:0] m_status;
    logic                         m_last;

    utf8_scoreboard sb = new();

    // Bytes accepted so far, and whether the sender is in a burst with no
    // idle cycles between beats.
    int bytes_sent = 0;
    bit send_burst = 1'b0;

    utf8_byte_decoder_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_byte_in   (s_byte_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_code_point(m_code_point),
        .m_status    (m_status),
        .m_last      (m_last)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Presents one byte beat and returns at the edge that accepts it. Valid
    // is left high on return, so a following beat with no gap keeps it up
    // without a drop; a gap lowers it once, in the step after acceptance.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if ($urandom_range(0, 39) == 0) begin
            send_burst = !send_burst;
        end
        gap = send_burst ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_byte_in <= b;
        do @(posedge aclk); while (!s_ready);
        sb.decode_byte(b);
        bytes_sent++;
    endtask

    // Drops valid and holds off until every predicted result has come back.
    // At least one edge passes, so valid never falls and rises in one step.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.waiting() != 0);
    endtask

    // Sends one lead byte and its continuation bytes, each drawn inside the
    // window the decoder must allow. A broken sequence stops early and ends
    // on an arbitrary byte, which may fall outside the window and so force
    // the error-then-relead path.
    task automatic send_sequence(input bit broken);
        logic [7:0] lead;
        logic [7:0] lo;
        logic [7:0] hi;
        int         conts;
        int         count;
        case ($urandom_range(0, 3))
            0: begin
                lead  = 8'($urandom_range(0, u8d_pkg::ASCII_MAX));
                conts = 0;
            end
            1: begin
                lead  = 8'($urandom_range(u8d_pkg::LEAD2_MIN, u8d_pkg::LEAD2_MAX));
                conts = 1;
            end
            2: begin
                // Bias toward the two leads that narrow the window.
                if ($urandom_range(0, 2) == 0) begin
                    lead = $urandom_range(0, 1) ? u8d_pkg::LEAD3_MIN
                                                : u8d_pkg::LEAD3_SURR;
                end else begin
                    lead = 8'($urandom_range(u8d_pkg::LEAD3_MIN, u8d_pkg::LEAD3_MAX));
                end
                conts = 2;
            end
            default: begin
                lead  = 8'($urandom_range(u8d_pkg::LEAD4_MIN, u8d_pkg::LEAD4_MAX));
                conts = 3;
            end
        endcase
        lo = (lead == u8d_pkg::LEAD3_MIN) ? u8d_pkg::E0_LO :
             (lead == u8d_pkg::LEAD4_MIN) ? u8d_pkg::F0_LO : u8d_pkg::CONT_LO;
        hi = (lead == u8d_pkg::LEAD3_SURR) ? u8d_pkg::ED_HI :
             (lead == u8d_pkg::LEAD4_MAX) ? u8d_pkg::F4_HI : u8d_pkg::CONT_HI;
        count = (broken && conts > 0) ? $urandom_range(0, conts - 1) : conts;
        send_byte(lead);
        for (int i = 0; i < count; i++) begin
            send_byte(8'($urandom_range(lo, hi)));
            lo = u8d_pkg::CONT_LO;
            hi = u8d_pkg::CONT_HI;
        end
        if (broken) begin
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // Stimulus: reset, a directed stream, then the random stream with one
    // full drain pause in the middle of it.
    initial begin
        logic [7:0] directed[$];
        int         first_random;
        bit         paused;
        directed = '{
            8'h00, 8'h7F,                // ASCII extremes
            8'h80, 8'hC1, 8'hF5, 8'hFF,  // bad lead bytes, no sequence open
            8'hC2, 8'h80,                // smallest two-byte value
            8'hE0, 8'hA0, 8'h80,         // smallest three-byte value
            8'hE0, 8'h9F,                // overlong three-byte form
            8'hED, 8'hA0,                // surrogate range
            8'hF0, 8'h8F,                // overlong four-byte form
            8'hF4, 8'h90,                // above the top scalar value
            8'hF4, 8'h8F, 8'hBF, 8'hBF,  // top scalar value
            8'hE1, 8'hC2, 8'h80,         // cut short by a new lead byte
            8'hC2, 8'h41                 // cut short by an ASCII byte
        };
        paused = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i]) begin
            send_byte(directed[i]);
        end
        drain_results();

        first_random = bytes_sent;
        while (bytes_sent - first_random < RANDOM_BYTES) begin
            if (!paused && bytes_sent - first_random > RANDOM_BYTES / 2) begin
                drain_results();
                paused = 1'b1;
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: send_sequence(1'b0);
                7, 8:                send_sequence(1'b1);
                default:             send_byte(8'($urandom_range(0, 255)));
            endcase
        end

        // Wait out every predicted result, then a few more cycles so that a
        // stray extra beat from the block is still caught.
        drain_results();
        repeat (16) @(posedge aclk);
        if (sb.failures == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Result side: random stalls with occasional stall-free stretches. Each
    // accepted result beat is handed to the scoreboard.
    initial begin
        int stall;
        bit burst;
        burst = 1'b0;
        do @(posedge aclk); while (aresetn !== 1'b1);
        forever begin
            if ($urandom_range(0, 39) == 0) begin
                burst = !burst;
            end
            stall = burst ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            sb.check_result(m_code_point, m_status, m_last);
        end
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

[sim.f]
+incdir+src
src/u8d_pkg.sv
src/u8d_front.sv
src/u8d_fifo.sv
src/u8d_back.sv
src/utf8_byte_decoder_unit.sv
bench/tb_utf8_byte_decoder_unit.sv
